// ===== rtl/gic_pkg.sv =====
`timescale 1ns / 1ps

package gic_pkg;

	// Item kinds carried in the slave-side tuser.
	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_READ = 2'd1,
		CMD_IRQ  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DEBOUNCE_RELOAD  = 2'd0,
		REG_RETRY_INTERVAL   = 2'd1,
		REG_RETRY_LIMIT      = 2'd2,
		REG_AXIS_INVERT_MASK = 2'd3
	} cfg_reg_t;

	localparam int NUM_AXES = 4;
	localparam int AXIS_W   = 8;
	localparam int CNT_W    = 4;

	localparam logic [CNT_W-1:0]    RELOAD_AT_RESET     = 4'd2;
	localparam logic [CNT_W-1:0]    RETRY_INTERVAL_RST  = 4'd10;
	localparam logic [CNT_W-1:0]    RETRY_LIMIT_RST     = 4'd10;
	localparam logic [NUM_AXES-1:0] INVERT_MASK_RST     = 4'd8;
	localparam logic [AXIS_W-1:0]   AXIS_CENTRE         = 8'd128;

	// Per-item control handed to the link controller.
	typedef struct packed {
		logic tick;
		logic rd_result;
		logic rd_ok;
		logic irq;
	} link_ctrl_t;

	typedef struct packed {
		logic req;
		logic error;
	} link_stat_t;

endpackage

// ===== rtl/gic_button_cell.sv =====
`timescale 1ns / 1ps

module gic_button_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,
	input  logic                    level,
	input  logic [gic_pkg::CNT_W-1:0] reload,
	output logic                    stable_d,
	output logic                    changed
);
	import gic_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_dec;
	logic             stable_q;
	logic             pressed;

	assign pressed   = ~level;
	assign count_dec = count_q - 1'b1;

	// The counter runs down only while the pin disagrees with the accepted state.
	always_comb begin
		count_d  = count_q;
		stable_d = stable_q;
		changed  = 1'b0;
		if (tick) begin
			if (pressed != stable_q) begin
				if (count_dec == '0) begin
					count_d  = reload;
					stable_d = ~stable_q;
					changed  = 1'b1;
				end else begin
					count_d = count_dec;
				end
			end else begin
				count_d = reload;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= RELOAD_AT_RESET;
			stable_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			stable_q <= stable_d;
		end
	end

endmodule

// ===== rtl/gic_axis_cal.sv =====
`timescale 1ns / 1ps

module gic_axis_cal (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic                      publish,
	input  logic                      invert,
	input  logic [gic_pkg::AXIS_W-1:0] raw,
	output logic [gic_pkg::AXIS_W-1:0] published_d
);
	import gic_pkg::*;

	localparam logic [AXIS_W-1:0] EDGE_LO   = 8'd10;
	localparam logic [AXIS_W-1:0] MID_LO    = 8'd110;
	localparam logic [AXIS_W-1:0] MID_HI    = 8'd146;
	localparam logic [AXIS_W-1:0] EDGE_HI   = 8'd245;
	localparam logic [AXIS_W-1:0] AXIS_MAX  = 8'd255;
	// 128/100 as 1311/1024; exact for offsets below 100.
	localparam logic [17:0]       SCALE_MUL = 18'd1311;
	localparam int                SCALE_SH  = 10;

	logic [AXIS_W-1:0] cal_q;
	logic [AXIS_W-1:0] pub_q;
	logic [AXIS_W-1:0] v;
	logic [6:0]        offs;
	logic [17:0]       prod;
	logic [AXIS_W-1:0] scaled;
	logic [AXIS_W-1:0] mapped;

	assign v      = invert ? ~raw : raw;
	assign offs   = (v < MID_LO) ? 7'(v - EDGE_LO) : 7'(v - MID_HI);
	assign prod   = 18'(offs) * SCALE_MUL;
	assign scaled = AXIS_W'(prod >> SCALE_SH);

	// Edge dead zones, two linear ramps and a flat centre.
	always_comb begin
		priority if (v < EDGE_LO) begin
			mapped = '0;
		end else if (v < MID_LO) begin
			mapped = scaled;
		end else if (v < MID_HI) begin
			mapped = AXIS_CENTRE;
		end else if (v < EDGE_HI) begin
			mapped = scaled + AXIS_CENTRE;
		end else begin
			mapped = AXIS_MAX;
		end
	end

	assign published_d = publish ? cal_q : pub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= AXIS_CENTRE;
			pub_q <= AXIS_CENTRE;
		end else begin
			if (load) begin
				cal_q <= mapped;
			end
			pub_q <= published_d;
		end
	end

endmodule

// ===== rtl/gic_link_ctrl.sv =====
`timescale 1ns / 1ps

module gic_link_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gic_pkg::link_ctrl_t       ctrl,
	input  logic [gic_pkg::CNT_W-1:0] retry_interval,
	input  logic [gic_pkg::CNT_W-1:0] retry_limit,
	output gic_pkg::link_stat_t       stat
);
	import gic_pkg::*;

	logic             error_q;
	logic [CNT_W-1:0] ticks_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ticks_d;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W:0]   ticks_inc;

	assign ticks_inc = {1'b0, ticks_q} + 1'b1;

	always_comb begin
		stat.error = error_q;
		stat.req   = 1'b0;
		ticks_d    = ticks_q;
		count_d    = count_q;
		if (ctrl.tick) begin
			if (error_q) begin
				if (ticks_inc > {1'b0, retry_interval}) begin
					ticks_d = '0;
					if (count_q < retry_limit) begin
						count_d  = count_q + 1'b1;
						stat.req = 1'b1;
					end
				end else begin
					ticks_d = ticks_inc[CNT_W-1:0];
				end
			end else begin
				ticks_d = '0;
				count_d = '0;
			end
		end
		if (ctrl.rd_result && !ctrl.rd_ok) begin
			stat.error = 1'b1;
		end
		if (ctrl.irq) begin
			stat.error = 1'b0;
			stat.req   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q <= 1'b1;
			ticks_q <= '0;
			count_q <= '0;
		end else begin
			error_q <= stat.error;
			ticks_q <= ticks_d;
			count_q <= count_d;
		end
	end

endmodule

// ===== rtl/gamepad_input_conditioner.sv =====
`timescale 1ns / 1ps

// Channel      Dir  Handshake                  Carries
// s_axis       in   s_axis_tvalid/tready       one item: tick, read result, interrupt or no-op
// m_axis       out  m_axis_tvalid/tready       one result per item
// cfg          in   cfg_valid/cfg_ready        register index and 4-bit value
//
// Every accepted item yields exactly one result beat, registered on the edge that accepts it.
// An item is taken every cycle as long as the output register is empty or its beat is
// being taken in the same cycle; the single output register sets that rate.
// Reset is asynchronous and active low; all state but the output data register returns
// to its defaults at once, so no clearing pass follows reset. A stall on the master side holds
// the result and back-pressures the slave side only while the output register is occupied.
module gamepad_input_conditioner #(
	parameter int NUM_BUTTONS = 15,
	localparam int IN_BITS  = NUM_BUTTONS + gic_pkg::NUM_AXES * gic_pkg::AXIS_W + 1,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * NUM_BUTTONS + gic_pkg::NUM_AXES * gic_pkg::AXIS_W + 2,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// button_levels, raw_axis_0, raw_axis_1, raw_axis_2, raw_axis_3, read_ok
	input  logic [IN_W-1:0]      s_axis_tdata,
	// command
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// pressed_state, changed_mask, axis_0, axis_1, axis_2, axis_3, request_read, link_error
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [gic_pkg::CNT_W-1:0] cfg_data
);
	import gic_pkg::*;

	localparam int AX_LSB  = NUM_BUTTONS;
	localparam int OK_BIT  = NUM_BUTTONS + NUM_AXES * AXIS_W;
	localparam int REQ_BIT = 2 * NUM_BUTTONS + NUM_AXES * AXIS_W;
	localparam int ERR_BIT = REQ_BIT + 1;

	// Configuration registers; the port never stalls.
	logic [CNT_W-1:0]    debounce_reload_q;
	logic [CNT_W-1:0]    retry_interval_q;
	logic [CNT_W-1:0]    retry_limit_q;
	logic [NUM_AXES-1:0] invert_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_reload_q <= RELOAD_AT_RESET;
			retry_interval_q  <= RETRY_INTERVAL_RST;
			retry_limit_q     <= RETRY_LIMIT_RST;
			invert_mask_q     <= INVERT_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE_RELOAD:  debounce_reload_q <= cfg_data;
				REG_RETRY_INTERVAL:   retry_interval_q  <= cfg_data;
				REG_RETRY_LIMIT:      retry_limit_q     <= cfg_data;
				REG_AXIS_INVERT_MASK: invert_mask_q     <= cfg_data;
			endcase
		end
	end

	// Input decode. All item-driven state updates happen on the accepting edge.
	logic       accept;
	cmd_t       cmd;
	logic       tick;
	logic       read_load;
	link_ctrl_t link_ctrl;
	link_stat_t link_stat;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cmd       = cmd_t'(s_axis_tuser);
	assign tick      = accept && (cmd == CMD_TICK);
	assign read_load = accept && (cmd == CMD_READ) && s_axis_tdata[OK_BIT];

	assign link_ctrl.tick      = tick;
	assign link_ctrl.rd_result = accept && (cmd == CMD_READ);
	assign link_ctrl.rd_ok     = s_axis_tdata[OK_BIT];
	assign link_ctrl.irq       = accept && (cmd == CMD_IRQ);

	// The row of debounce cells, one per button, each holding its own counter
	// and accepted state.
	logic [NUM_BUTTONS-1:0] stable_d;
	logic [NUM_BUTTONS-1:0] changed;

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		gic_button_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tick     (tick),
			.level    (s_axis_tdata[b]),
			.reload   (debounce_reload_q),
			.stable_d (stable_d[b]),
			.changed  (changed[b])
		);
	end

	// One calibration slice per axis. A successful read result loads the
	// calibrated value; a tick copies it to the published value.
	logic [NUM_AXES*AXIS_W-1:0] published_d;

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		gic_axis_cal u_axis (
			.clk         (clk),
			.arst_n      (arst_n),
			.load        (read_load),
			.publish     (tick),
			.invert      (invert_mask_q[a]),
			.raw         (s_axis_tdata[AX_LSB + a*AXIS_W +: AXIS_W]),
			.published_d (published_d[a*AXIS_W +: AXIS_W])
		);
	end

	// Link error flag and retry pacing.
	gic_link_ctrl u_link (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (link_ctrl),
		.retry_interval (retry_interval_q),
		.retry_limit    (retry_limit_q),
		.stat           (link_stat)
	);

	// Output register. It refills on the same edge its beat is taken.
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= OUT_W'({link_stat.error, link_stat.req, published_d,
				changed, stable_d});
		end
	end

	// A read result never asks for another read.
	a_read_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_READ |=> !m_axis_tdata[REQ_BIT])
		else $error("read result produced a read request");

	// An interrupt clears the link error and always asks for a read.
	a_irq_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_IRQ |=> m_axis_tdata[REQ_BIT] && !m_axis_tdata[ERR_BIT])
		else $error("interrupt result wrong");

	// Only ticks can change debounced buttons.
	a_changed_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd != CMD_TICK |=> m_axis_tdata[2*NUM_BUTTONS-1:NUM_BUTTONS] == '0)
		else $error("button change reported outside a tick");

	// A failed read always leaves the link in error.
	a_fail_sets_error: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_READ && !s_axis_tdata[OK_BIT] |=> m_axis_tdata[ERR_BIT])
		else $error("failed read did not raise link error");

endmodule
